// ===== design/dgvi_pkg.sv =====
package dgvi_pkg;

  // Grid size register and effective detail
  localparam int DW = 7;
  // Vertex index fields
  localparam int IDX_W = 12;
  // pi/2 in Q30
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  // Serial divider: dividend and divisor widths
  localparam int DIV_W = 38;
  localparam int DVS_W = 9;
  // Taylor terms after the linear one
  localparam logic [3:0] TERMS = 4'd8;

  typedef enum logic [1:0] {
    KIND_QUAD = 2'd0,
    KIND_TRI  = 2'd1,
    KIND_POLE = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  // Sine table select
  localparam logic TBL_RING = 1'b0;
  localparam logic TBL_COL  = 1'b1;

  typedef enum logic [3:0] {
    BLD_IDLE,
    BLD_LOAD,
    BLD_ANG_DIV,
    BLD_SQUARE,
    BLD_SQ_SHIFT,
    BLD_TERM_MUL,
    BLD_TERM_LOAD,
    BLD_TERM_DIV,
    BLD_TERM_ACC,
    BLD_WRITE
  } bld_state_t;

  typedef struct packed {
    logic we;
    logic sel;
  } tbl_wr_t;

  typedef struct packed {
    kind_t             kind;
    logic [1:0]        quad;
    logic [DW-1:0]     sth_addr;
    logic [DW-1:0]     cth_addr;
    logic [DW-1:0]     sa_addr;
    logic [DW-1:0]     sb_addr;
    logic [IDX_W-1:0]  tri0_a;
    logic [IDX_W-1:0]  tri0_b;
    logic [IDX_W-1:0]  tri0_c;
    logic [IDX_W-1:0]  tri1_a;
    logic [IDX_W-1:0]  tri1_b;
    logic [IDX_W-1:0]  tri1_c;
  } item_t;

  // Divisor (2k)(2k+1) of Taylor term k
  function automatic logic [DVS_W-1:0] term_div(input logic [3:0] k);
    logic [DVS_W-1:0] dv;
    case (k)
      4'd1:    dv = 9'd6;
      4'd2:    dv = 9'd20;
      4'd3:    dv = 9'd42;
      4'd4:    dv = 9'd72;
      4'd5:    dv = 9'd110;
      4'd6:    dv = 9'd156;
      4'd7:    dv = 9'd210;
      4'd8:    dv = 9'd272;
      default: dv = 9'd1;
    endcase
    return dv;
  endfunction

  // Clamp the register value to [3, cap]
  function automatic logic [DW-1:0] clamp_detail(input logic [DW-1:0] det,
                                                 input logic [DW-1:0] cap);
    logic [DW-1:0] v;
    v = det;
    if (v < 7'd3) v = 7'd3;
    if (v > cap) v = cap;
    return v;
  endfunction

endpackage

// ===== design/dome_grid_vertex_and_index_gen.sv =====
// Dome grid point generator: one hemisphere grid point (ring, column) in,
// one transaction out with kind, Q1.14 position, unsigned Q2.14 texture coordinates
// and the vertex indices of the triangles anchored at that cell.
// Input channel in_valid/in_ready carries in_ring and in_column; the result
// channel out_valid/out_ready carries the out_ fields. cfg_we with cfg_wdata
// writes the detail register (rings and columns, clamped to [3, DETAIL_MAX]).
// Throughput is one transaction per clock while no table build runs and the
// receiver is ready; out_valid follows the accepting edge through the queue
// slot write, the table read, the multiply and the output register.
// Sines come from two small tables holding the quarter-wave values for the
// current detail. A serial builder (one divider bit per clock, 2D+1 entries)
// fills them after reset and after each detail write.
// in_ready is low while the tables are filled.
// When the receiver stalls, the output register holds its transaction, the
// back pipeline freezes, and the two-entry queue absorbs the front until it
// is full, at which point in_ready drops.
module dome_grid_vertex_and_index_gen #(
  parameter int DETAIL_MAX = 64,
  parameter int FRAC_BITS  = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [5:0]          in_ring,
  input  logic [5:0]          in_column,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic signed [15:0]  out_pos_x,
  output logic signed [15:0]  out_pos_y,
  output logic signed [15:0]  out_pos_z,
  output logic [15:0]         out_tex_u,
  output logic [15:0]         out_tex_v,
  output logic [11:0]         out_tri0_a,
  output logic [11:0]         out_tri0_b,
  output logic [11:0]         out_tri0_c,
  output logic [11:0]         out_tri1_a,
  output logic [11:0]         out_tri1_b,
  output logic [11:0]         out_tri1_c,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata
);
  import dgvi_pkg::*;

  localparam int DCAP  = (DETAIL_MAX < 127) ? DETAIL_MAX : 127;
  localparam int DEPTH = DCAP + 1;
  localparam int TAW   = $clog2(DEPTH);
  localparam logic [15:0] TEX_OFS = 16'(64'd1 << FRAC_BITS);

  logic [DW-1:0]      detail_r, detail_nxt, det;
  logic               start_r;
  logic               bld_busy;
  tbl_wr_t            wr;
  logic [TAW-1:0]     wr_addr;
  logic [FRAC_BITS:0] wr_data;
  item_t              f_item, q_head;
  logic               q_push, q_pop, q_full, q_empty;

  // Detail register; a write restarts the table build
  assign detail_nxt = cfg_we ? cfg_wdata : detail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      detail_r <= 7'd16;
      start_r  <= 1'b1;
    end else begin
      detail_r <= detail_nxt;
      start_r  <= cfg_we;
    end
  end

  assign det      = clamp_detail(detail_r, DW'(DCAP));
  assign in_ready = !bld_busy && !start_r && !q_full;
  assign q_push   = in_valid && in_ready;

  dgvi_sine_build #(
    .FRAC_BITS (FRAC_BITS),
    .TAW       (TAW)
  ) u_build (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_r),
    .det     (det),
    .busy    (bld_busy),
    .wr      (wr),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  dgvi_front u_front (
    .ring   (in_ring),
    .column (in_column),
    .det    (det),
    .item   (f_item)
  );

  dgvi_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (f_item),
    .pop       (q_pop),
    .head_item (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  dgvi_back #(
    .FRAC_BITS (FRAC_BITS),
    .DEPTH     (DEPTH),
    .TAW       (TAW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_item     (q_head),
    .q_valid    (!q_empty),
    .q_pop      (q_pop),
    .wr         (wr),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (out_kind),
    .out_pos_x  (out_pos_x),
    .out_pos_y  (out_pos_y),
    .out_pos_z  (out_pos_z),
    .out_tex_u  (out_tex_u),
    .out_tex_v  (out_tex_v),
    .out_tri0_a (out_tri0_a),
    .out_tri0_b (out_tri0_b),
    .out_tri0_c (out_tri0_c),
    .out_tri1_a (out_tri1_a),
    .out_tri1_b (out_tri1_b),
    .out_tri1_c (out_tri1_c)
  );

  // A detail write blocks input while the tables are rebuilt
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input accepted right after a detail write");

  // Outside points carry nothing but their kind
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_NONE) |->
      (out_pos_x == 16'sd0 && out_pos_y == 16'sd0 && out_pos_z == 16'sd0 &&
       out_tex_u == 16'd0 && out_tex_v == 16'd0 && out_tri0_a == 12'd0 &&
       out_tri1_a == 12'd0 && out_tri0_b == 12'd0))
    else $error("outside point with non-zero payload");

  // Texture coordinates track the position exactly
  a_tex_track: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_NONE) |->
      (out_tex_u == 16'(out_pos_x + TEX_OFS) && out_tex_v == 16'(out_pos_z + TEX_OFS)))
    else $error("texture coordinate does not match position");

  // Pole vertex has no triangles
  a_pole_tris: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_POLE) |->
      (out_tri0_a == 12'd0 && out_tri0_b == 12'd0 && out_tri1_c == 12'd0))
    else $error("pole vertex carries triangle indices");

endmodule

// ===== design/dgvi_front.sv =====
module dgvi_front (
  input  logic [5:0]            ring,
  input  logic [5:0]            column,
  input  logic [dgvi_pkg::DW-1:0] det,
  output dgvi_pkg::item_t       item
);
  import dgvi_pkg::*;

  logic [6:0]  ring7, col7, d1, c1, col_inc;
  logic [8:0]  q9, dx1, dx2, dx3, sub, rem9;
  logic [1:0]  quad;
  logic        outside;
  logic [12:0] base, next_row;
  logic [13:0] pole;

  // Split the azimuth into quadrant and remainder with three compares
  always_comb begin
    ring7 = {1'b0, ring};
    col7  = {1'b0, column};
    d1    = det - 7'd1;
    q9    = {1'b0, column, 2'b00};
    dx1   = {2'b00, det};
    dx2   = {1'b0, det, 1'b0};
    dx3   = dx1 + dx2;
    if (q9 >= dx3) begin
      quad = 2'd3;
      sub  = dx3;
    end else if (q9 >= dx2) begin
      quad = 2'd2;
      sub  = dx2;
    end else if (q9 >= dx1) begin
      quad = 2'd1;
      sub  = dx1;
    end else begin
      quad = 2'd0;
      sub  = 9'd0;
    end
    rem9 = q9 - sub;
  end

  // Row bases, pole index, outside flag and wrapped neighbour column
  always_comb begin
    col_inc  = col7 + 7'd1;
    c1       = (col_inc == det) ? 7'd0 : col_inc;
    base     = 13'(ring7) * 13'(det);
    next_row = base + 13'(det);
    pole     = 14'(det) * 14'(d1);
    outside  = (ring7 >= det) || (col7 >= det) || ((ring7 == d1) && (col7 != 7'd0));
  end

  // Classify and build the triangle indices
  always_comb begin
    item          = '0;
    item.quad     = quad;
    item.sth_addr = d1 - ring7;
    item.cth_addr = ring7;
    item.sa_addr  = rem9[6:0];
    item.sb_addr  = det - rem9[6:0];
    if (outside) begin
      item.kind = KIND_NONE;
    end else if (ring7 == d1) begin
      item.kind = KIND_POLE;
    end else if (ring7 == d1 - 7'd1) begin
      item.kind   = KIND_TRI;
      item.tri0_a = 12'(base + 13'(col7));
      item.tri0_b = pole[11:0];
      item.tri0_c = 12'(base + 13'(c1));
    end else begin
      item.kind   = KIND_QUAD;
      item.tri0_a = 12'(base + 13'(col7));
      item.tri0_b = 12'(next_row + 13'(col7));
      item.tri0_c = 12'(next_row + 13'(c1));
      item.tri1_a = 12'(base + 13'(col7));
      item.tri1_b = 12'(next_row + 13'(c1));
      item.tri1_c = 12'(base + 13'(c1));
    end
  end

endmodule

// ===== design/dgvi_queue.sv =====
module dgvi_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dgvi_pkg::item_t push_item,
  input  logic            pop,
  output dgvi_pkg::item_t head_item,
  output logic            full,
  output logic            empty
);
  import dgvi_pkg::*;

  item_t      slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  // Advance pointers and fill count
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_item;
  end

  assign head_item = slot_r[rp_r];
  assign full      = (cnt_r == 2'd2);
  assign empty     = (cnt_r == 2'd0);

endmodule

// ===== design/dgvi_sine_build.sv =====
module dgvi_sine_build #(
  parameter int FRAC_BITS = 14,
  parameter int TAW       = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [dgvi_pkg::DW-1:0] det,
  output logic                    busy,
  output dgvi_pkg::tbl_wr_t       wr,
  output logic [TAW-1:0]          wr_addr,
  output logic [FRAC_BITS:0]      wr_data
);
  import dgvi_pkg::*;

  localparam int SH = 30 - FRAC_BITS;
  localparam logic [34:0] RND = (35'd1 << SH) >> 1;
  localparam logic [34:0] ONE = 35'd1 << FRAC_BITS;

  bld_state_t         state_r, state_nxt;
  logic [DW-1:0]      d_r, n_r, den;
  logic               sel_r;
  logic [3:0]         k_r;
  logic [DIV_W-1:0]   quo_r, quo_step, ang_div;
  logic [DVS_W-1:0]   rem_r, dvs_r, rem_step;
  logic [DVS_W:0]     trial;
  logic               ge;
  logic [5:0]         cnt_r;
  logic               div_done;
  logic [31:0]        x2_r, term_r;
  logic [63:0]        prod_r;
  logic signed [33:0] sum_r;
  logic [33:0]        sum_pos;
  logic [34:0]        rnd_full;
  logic               last_val;

  // One restoring divider step per cycle
  always_comb begin
    trial    = {rem_r, quo_r[DIV_W-1]};
    ge       = trial >= {1'b0, dvs_r};
    rem_step = ge ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
    quo_step = {quo_r[DIV_W-2:0], ge};
    div_done = (cnt_r == 6'(DIV_W - 1));
  end

  // Angle and rounding of the finished series
  always_comb begin
    den      = sel_r ? d_r : d_r - 7'd1;
    ang_div  = DIV_W'(38'(n_r) * 38'(HALF_PI_Q30)) + DIV_W'(den >> 1);
    sum_pos  = sum_r[33] ? 34'd0 : 34'(sum_r);
    rnd_full = (35'(sum_pos) + RND) >> SH;
    last_val = (n_r == den);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BLD_IDLE:      state_nxt = BLD_IDLE;
      BLD_LOAD:      state_nxt = BLD_ANG_DIV;
      BLD_ANG_DIV:   if (div_done) state_nxt = BLD_SQUARE;
      BLD_SQUARE:    state_nxt = BLD_SQ_SHIFT;
      BLD_SQ_SHIFT:  state_nxt = BLD_TERM_MUL;
      BLD_TERM_MUL:  state_nxt = BLD_TERM_LOAD;
      BLD_TERM_LOAD: state_nxt = BLD_TERM_DIV;
      BLD_TERM_DIV:  if (div_done) state_nxt = BLD_TERM_ACC;
      BLD_TERM_ACC:  state_nxt = (k_r == TERMS) ? BLD_WRITE : BLD_TERM_MUL;
      BLD_WRITE:     state_nxt = (last_val && sel_r == TBL_COL) ? BLD_IDLE : BLD_LOAD;
      default:       state_nxt = BLD_IDLE;
    endcase
    if (start) state_nxt = BLD_LOAD;
  end

  // Outputs
  always_comb begin
    busy    = (state_r != BLD_IDLE);
    wr.we   = (state_r == BLD_WRITE);
    wr.sel  = sel_r;
    wr_addr = n_r[TAW-1:0];
    wr_data = (rnd_full > ONE) ? ONE[FRAC_BITS:0] : rnd_full[FRAC_BITS:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BLD_IDLE;
    else        state_r <= state_nxt;
  end

  // Datapath: table walk, divider and series
  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= det;
      n_r   <= '0;
      sel_r <= TBL_RING;
    end else begin
      case (state_r)
        BLD_LOAD: begin
          quo_r <= ang_div;
          rem_r <= '0;
          cnt_r <= '0;
          dvs_r <= DVS_W'(den);
        end
        BLD_ANG_DIV, BLD_TERM_DIV: begin
          quo_r <= quo_step;
          rem_r <= rem_step;
          cnt_r <= cnt_r + 6'd1;
        end
        BLD_SQUARE: begin
          prod_r <= quo_r[31:0] * quo_r[31:0];
          term_r <= quo_r[31:0];
          sum_r  <= signed'(34'(quo_r[31:0]));
          k_r    <= 4'd1;
        end
        BLD_SQ_SHIFT: x2_r <= prod_r[61:30];
        BLD_TERM_MUL: prod_r <= term_r * x2_r;
        BLD_TERM_LOAD: begin
          quo_r <= DIV_W'(prod_r[63:30]);
          rem_r <= '0;
          cnt_r <= '0;
          dvs_r <= term_div(k_r);
        end
        BLD_TERM_ACC: begin
          term_r <= quo_r[31:0];
          if (k_r[0]) sum_r <= sum_r - signed'(34'(quo_r[31:0]));
          else        sum_r <= sum_r + signed'(34'(quo_r[31:0]));
          k_r <= k_r + 4'd1;
        end
        BLD_WRITE: begin
          if (last_val) begin
            n_r   <= '0;
            sel_r <= TBL_COL;
          end else begin
            n_r <= n_r + 7'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/dgvi_back.sv =====
module dgvi_back #(
  parameter int FRAC_BITS = 14,
  parameter int DEPTH     = 65,
  parameter int TAW       = 7
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dgvi_pkg::item_t        q_item,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  dgvi_pkg::tbl_wr_t      wr,
  input  logic [TAW-1:0]         wr_addr,
  input  logic [FRAC_BITS:0]     wr_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_kind,
  output logic signed [15:0]     out_pos_x,
  output logic signed [15:0]     out_pos_y,
  output logic signed [15:0]     out_pos_z,
  output logic [15:0]            out_tex_u,
  output logic [15:0]            out_tex_v,
  output logic [11:0]            out_tri0_a,
  output logic [11:0]            out_tri0_b,
  output logic [11:0]            out_tri0_c,
  output logic [11:0]            out_tri1_a,
  output logic [11:0]            out_tri1_b,
  output logic [11:0]            out_tri1_c
);
  import dgvi_pkg::*;

  localparam int VW  = FRAC_BITS + 1;
  localparam int PW  = 2 * VW;
  localparam int XW  = FRAC_BITS + 2;
  localparam int OW  = (XW > 16) ? XW : 16;
  localparam logic [PW:0]   RND = (PW+1)'(1) << (FRAC_BITS - 1);
  localparam logic [OW-1:0] ONE = OW'(1) << FRAC_BITS;

  logic [VW-1:0] tbl_ring [DEPTH];
  logic [VW-1:0] tbl_col  [DEPTH];

  logic           en;
  logic           s1_valid_r, s2_valid_r, out_valid_r;
  item_t          s1_item_r, s2_item_r;
  logic [VW-1:0]  th_s_r, th_c_r, al_a_r, al_b_r, y_r;
  logic [VW-1:0]  mag_s, mag_c;
  logic [PW-1:0]  px_r, pz_r;
  logic [PW:0]    px_rnd, pz_rnd;
  logic [XW-1:0]  px, pz;
  logic signed [XW-1:0] xs, zs;
  logic signed [OW-1:0] xe, ze;
  logic [OW-1:0]  ye;

  logic [1:0]  kind_r;
  logic [15:0] pos_x_r, pos_y_r, pos_z_r, tex_u_r, tex_v_r;
  logic [11:0] t0a_r, t0b_r, t0c_r, t1a_r, t1b_r, t1c_r;

  // Whole pipeline advances unless the output is held
  assign en    = !out_valid_r || out_ready;
  assign q_pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= q_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  // Sine tables: written by the builder, two registered reads each
  always_ff @(posedge clk) begin
    if (wr.we && wr.sel == TBL_RING) tbl_ring[wr_addr] <= wr_data;
    if (en) begin
      th_s_r <= tbl_ring[q_item.sth_addr[TAW-1:0]];
      th_c_r <= tbl_ring[q_item.cth_addr[TAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we && wr.sel == TBL_COL) tbl_col[wr_addr] <= wr_data;
    if (en) begin
      al_a_r <= tbl_col[q_item.sa_addr[TAW-1:0]];
      al_b_r <= tbl_col[q_item.sb_addr[TAW-1:0]];
    end
  end

  // Stage 2: pick azimuth magnitudes and multiply
  always_comb begin
    mag_s = s1_item_r.quad[0] ? al_b_r : al_a_r;
    mag_c = s1_item_r.quad[0] ? al_a_r : al_b_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item_r <= q_item;
      s2_item_r <= s1_item_r;
      px_r      <= PW'(th_s_r) * PW'(mag_s);
      pz_r      <= PW'(th_s_r) * PW'(mag_c);
      y_r       <= th_c_r;
    end
  end

  // Stage 3: round half up on magnitudes, then apply the sign
  always_comb begin
    px_rnd = ((PW+1)'(px_r) + RND) >> FRAC_BITS;
    pz_rnd = ((PW+1)'(pz_r) + RND) >> FRAC_BITS;
    px     = px_rnd[XW-1:0];
    pz     = pz_rnd[XW-1:0];
    xs     = (s2_item_r.quad[1] == 1'b0) ? -signed'(px) : signed'(px);
    zs     = (s2_item_r.quad == 2'd0 || s2_item_r.quad == 2'd3) ?
             -signed'(pz) : signed'(pz);
    xe     = OW'(xs);
    ze     = OW'(zs);
    ye     = OW'(y_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_r <= s2_item_r.kind;
      t0a_r  <= s2_item_r.tri0_a;
      t0b_r  <= s2_item_r.tri0_b;
      t0c_r  <= s2_item_r.tri0_c;
      t1a_r  <= s2_item_r.tri1_a;
      t1b_r  <= s2_item_r.tri1_b;
      t1c_r  <= s2_item_r.tri1_c;
      if (s2_item_r.kind == KIND_NONE) begin
        pos_x_r <= '0;
        pos_y_r <= '0;
        pos_z_r <= '0;
        tex_u_r <= '0;
        tex_v_r <= '0;
      end else begin
        pos_x_r <= xe[15:0];
        pos_y_r <= ye[15:0];
        pos_z_r <= ze[15:0];
        tex_u_r <= 16'(xe + signed'(ONE));
        tex_v_r <= 16'(ze + signed'(ONE));
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = kind_r;
  assign out_pos_x  = signed'(pos_x_r);
  assign out_pos_y  = signed'(pos_y_r);
  assign out_pos_z  = signed'(pos_z_r);
  assign out_tex_u  = tex_u_r;
  assign out_tex_v  = tex_v_r;
  assign out_tri0_a = t0a_r;
  assign out_tri0_b = t0b_r;
  assign out_tri0_c = t0c_r;
  assign out_tri1_a = t1a_r;
  assign out_tri1_b = t1b_r;
  assign out_tri1_c = t1c_r;

endmodule

// ===== tb/dome_grid_vertex_and_index_gen_tb.sv =====
module dome_grid_vertex_and_index_gen_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dgvi_pkg::*;

  localparam int GRID_CAP = 64;
  localparam int QFRAC = 14;
  localparam longint unsigned HALF_PI = 64'd1686629713;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    kind_t              kind;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    logic [15:0]        tu;
    logic [15:0]        tv;
    logic [11:0]        tri_idx [6];
  } grid_point_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [5:0]         in_ring = '0;
  logic [5:0]         in_column = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_kind;
  logic signed [15:0] out_pos_x, out_pos_y, out_pos_z;
  logic [15:0]        out_tex_u, out_tex_v;
  logic [11:0]        out_tri0_a, out_tri0_b, out_tri0_c;
  logic [11:0]        out_tri1_a, out_tri1_b, out_tri1_c;
  logic               cfg_we = 1'b0;
  logic [6:0]         cfg_wdata = '0;

  grid_point_t pending_points[$];
  logic [6:0]  detail_shadow = 7'd16;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;
  int          errors = 0;
  int          points_sent = 0;
  int          points_checked = 0;
  int          cycles = 0;

  dome_grid_vertex_and_index_gen dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_ring(in_ring), .in_column(in_column),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(out_kind),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_tex_u(out_tex_u), .out_tex_v(out_tex_v),
    .out_tri0_a(out_tri0_a), .out_tri0_b(out_tri0_b), .out_tri0_c(out_tri0_c),
    .out_tri1_a(out_tri1_a), .out_tri1_b(out_tri1_b), .out_tri1_c(out_tri1_c),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d transactions outstanding", cycles,
               pending_points.size());
      $display("dome_grid_vertex_and_index_gen_tb: FAIL");
      $finish;
    end
  end

  // Quarter-wave sine for angle pi/2 * n/d, Taylor series in Q30
  function automatic longint quarter_wave(longint unsigned n, longint unsigned d);
    longint unsigned x, x2, term, r;
    longint          acc;
    if (d == 0) return 0;
    if (n > d) n = d;
    x = (n * HALF_PI + d / 2) / d;
    x2 = (x * x) >> 30;
    acc = longint'(x);
    term = x;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    r = (longint'(acc) + (64'd1 << (29 - QFRAC))) >> (30 - QFRAC);
    if (r > (64'd1 << QFRAC)) r = 64'd1 << QFRAC;
    return longint'(r);
  endfunction

  // Product rounded half up on magnitudes, sign applied afterwards
  function automatic longint q14_product(longint a, longint b);
    longint ma, mb, p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = (ma * mb + (64'd1 << (QFRAC - 1))) >> QFRAC;
    return ((a < 0) != (b < 0)) ? -p : p;
  endfunction

  function automatic grid_point_t predict_point(logic [5:0] ring, logic [5:0] col);
    grid_point_t g;
    longint d, d1, r, c, quad, rem, c1, s_th, c_th, sa, sb, s_al, c_al, x, z;
    g.kind = KIND_NONE;
    g.px = '0; g.py = '0; g.pz = '0; g.tu = '0; g.tv = '0;
    for (int i = 0; i < 6; i++) g.tri_idx[i] = '0;
    d = detail_shadow;
    if (d < 3) d = 3;
    if (d > GRID_CAP) d = GRID_CAP;
    d1 = d - 1;
    r = ring;
    c = col;
    if (r >= d || c >= d || (r == d1 && c != 0)) return g;
    s_th = -quarter_wave(d1 - r, d1);
    c_th = quarter_wave(r, d1);
    quad = (4 * c) / d;
    rem = (4 * c) % d;
    sa = quarter_wave(rem, d);
    sb = quarter_wave(d - rem, d);
    case (quad % 4)
      0: begin s_al = sa;  c_al = sb;  end
      1: begin s_al = sb;  c_al = -sa; end
      2: begin s_al = -sa; c_al = -sb; end
      default: begin s_al = -sb; c_al = sa; end
    endcase
    x = q14_product(s_th, s_al);
    z = q14_product(s_th, c_al);
    g.px = x[15:0];
    g.py = c_th[15:0];
    g.pz = z[15:0];
    x = x + (64'd1 << QFRAC);
    z = z + (64'd1 << QFRAC);
    g.tu = x[15:0];
    g.tv = z[15:0];
    c1 = (c + 1 == d) ? 0 : c + 1;
    if (r == d1) begin
      g.kind = KIND_POLE;
    end else if (r == d1 - 1) begin
      g.kind = KIND_TRI;
      g.tri_idx[0] = 12'(r * d + c);
      g.tri_idx[1] = 12'(d * d1);
      g.tri_idx[2] = 12'(r * d + c1);
    end else begin
      g.kind = KIND_QUAD;
      g.tri_idx[0] = 12'(r * d + c);
      g.tri_idx[1] = 12'((r + 1) * d + c);
      g.tri_idx[2] = 12'((r + 1) * d + c1);
      g.tri_idx[3] = 12'(r * d + c);
      g.tri_idx[4] = 12'((r + 1) * d + c1);
      g.tri_idx[5] = 12'(r * d + c1);
    end
    return g;
  endfunction

  function automatic int grid_size();
    int d;
    d = detail_shadow;
    if (d < 3) d = 3;
    if (d > GRID_CAP) d = GRID_CAP;
    return d;
  endfunction

  // Offer one grid point, with random gaps ahead of it
  task automatic send_point(input logic [5:0] ring, input logic [5:0] col);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_ring <= ring;
    in_column <= col;
    do @(posedge clk); while (!in_ready);
    pending_points.insert(pending_points.size(), predict_point(ring, col));
    points_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_points.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write the detail register once the pipeline is empty
  task automatic set_detail(input logic [6:0] value);
    drain_results();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    detail_shadow = value;
  endtask

  // Grid corners, wrap column, ring below the pole, pole and outside points
  task automatic test_grid_edges();
    int d;
    d = grid_size();
    send_point(0, 0);
    send_point(0, 6'(d - 1));
    send_point(1, 6'(d / 4));
    send_point(1, 6'(d / 2));
    send_point(1, 6'((3 * d) / 4));
    send_point(6'(d - 3), 6'(d - 1));
    send_point(6'(d - 2), 0);
    send_point(6'(d - 2), 6'(d - 1));
    send_point(6'(d - 1), 0);
    send_point(6'(d - 1), 1);
    send_point(6'(d - 1), 6'(d - 1));
    send_point(0, 6'(d));
    send_point(6'(d), 0);
    send_point(63, 63);
    send_point(0, 63);
    send_point(63, 0);
    release_input();
  endtask

  // Mostly points on the grid, some anywhere in the field range
  task automatic test_random_points(input int count, input int gaps, input int stalls);
    int d;
    d = grid_size();
    gap_pct = gaps;
    stall_pct = stalls;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 8)
        send_point(6'($urandom_range(d - 1)), 6'($urandom_range(d - 1)));
      else
        send_point(6'($urandom), 6'($urandom));
    end
    release_input();
  endtask

  // Hold the receiver off so the queue fills and in_ready drops
  task automatic test_output_backpressure();
    gap_pct = 0;
    stall_pct = 0;
    @(negedge clk);
    hold_left = 200;
    for (int i = 0; i < 40; i++)
      send_point(6'($urandom_range(grid_size() - 1)), 6'($urandom));
    release_input();
  endtask

  // Receiver: long hold when asked, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    grid_point_t g;
    if (rst_n && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        errors++;
        $display("%0t: result with no point outstanding: kind %0d", $time, out_kind);
      end else begin
        g = pending_points.pop_front();
        points_checked++;
        check_field("kind", g.kind, out_kind);
        check_field("pos_x", g.px, out_pos_x);
        check_field("pos_y", g.py, out_pos_y);
        check_field("pos_z", g.pz, out_pos_z);
        check_field("tex_u", g.tu, out_tex_u);
        check_field("tex_v", g.tv, out_tex_v);
        check_field("tri0_a", g.tri_idx[0], out_tri0_a);
        check_field("tri0_b", g.tri_idx[1], out_tri0_b);
        check_field("tri0_c", g.tri_idx[2], out_tri0_c);
        check_field("tri1_a", g.tri_idx[3], out_tri1_a);
        check_field("tri1_b", g.tri_idx[4], out_tri1_b);
        check_field("tri1_c", g.tri_idx[5], out_tri1_c);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset detail
    test_grid_edges();
    test_random_points(130, 0, 0);
    // Smallest grid
    set_detail(7'd3);
    test_grid_edges();
    test_random_points(100, 78, 0);
    // Below range: clamps to the smallest grid
    set_detail(7'd0);
    test_random_points(80, 0, 78);
    // Largest grid
    set_detail(7'd64);
    test_grid_edges();
    test_random_points(200, 22, 22);
    test_output_backpressure();
    // Above range: clamps to the largest grid
    set_detail(7'd127);
    test_random_points(100, 0, 0);
    // Odd size
    set_detail(7'd37);
    test_grid_edges();
    test_random_points(120, 22, 22);

    drain_results();
    $display("covered %0d grid points, %0d results checked, details 16, 3, 0, 64, 127, 37",
             points_sent, points_checked);
    $display("idle and stall mixes plus one long receiver hold-off");
    if (errors == 0)
      $display("dome_grid_vertex_and_index_gen_tb: PASS");
    else
      $display("dome_grid_vertex_and_index_gen_tb: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
design/dgvi_pkg.sv
design/dgvi_front.sv
design/dgvi_queue.sv
design/dgvi_sine_build.sv
design/dgvi_back.sv
design/dome_grid_vertex_and_index_gen.sv
tb/dome_grid_vertex_and_index_gen_tb.sv
